// File: hw/rtl/sm3_pkg.sv
// shared types, constants and helper functions for the sm3 hash block
package sm3_pkg;

    localparam int WORD_W     = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int CHAIN_WORDS = 8;
    localparam int ROUNDS      = 64;
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int FILL_W      = $clog2(BLOCK_WORDS);
    localparam int OUT_IDX_W   = $clog2(CHAIN_WORDS);

    // first word that holds the bit length (byte offset 56)
    localparam int LEN_WORD     = 56 / 4;
    localparam int LOW_ROUNDS   = 16;

    localparam logic [7:0]        PAD_MARKER  = 8'h80;
    localparam logic [WORD_W-1:0] MARKER_WORD = {PAD_MARKER, 24'h00_0000};
    localparam logic [WORD_W-1:0] T_LOW       = 32'h79cc_4519;
    localparam logic [WORD_W-1:0] T_HIGH      = 32'h7a87_9d8a;
    localparam logic [2:0]        FULL_BYTES  = 3'd4;

    typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] block_t;
    typedef logic [CHAIN_WORDS-1:0][WORD_W-1:0] chain_t;

    localparam chain_t SM3_IV = {
        32'hb0fb_0e4e, 32'he38d_ee4d, 32'h1631_38aa, 32'ha96f_30bc,
        32'hda8a_0600, 32'h1724_42d7, 32'h4914_b2b9, 32'h7380_166f
    };

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        end_of_message;
    } sm3_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } sm3_out_t;

    typedef struct packed {
        logic start;
        logic clear;
    } core_ctrl_t;

    typedef struct packed {
        logic done;
    } core_stat_t;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input int n);
        rotl32 = (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] perm0(input logic [WORD_W-1:0] x);
        perm0 = x ^ rotl32(x, 9) ^ rotl32(x, 17);
    endfunction

    function automatic logic [WORD_W-1:0] perm1(input logic [WORD_W-1:0] x);
        perm1 = x ^ rotl32(x, 15) ^ rotl32(x, 23);
    endfunction

    // keep the leading valid bytes and place the marker right after them
    function automatic logic [WORD_W-1:0] pad_tail(input logic [WORD_W-1:0] w,
                                                   input logic [2:0] nv);
        unique case (nv)
            3'd0:    pad_tail = MARKER_WORD;
            3'd1:    pad_tail = {w[31:24], PAD_MARKER, 16'h0000};
            3'd2:    pad_tail = {w[31:16], PAD_MARKER, 8'h00};
            3'd3:    pad_tail = {w[31:8], PAD_MARKER};
            default: pad_tail = w;
        endcase
    endfunction

endpackage

// File: hw/rtl/sm3_core.sv
// sm3 compression core: one round per cycle with a sliding expansion window
module sm3_core
    import sm3_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  core_ctrl_t ctrl,
    input  block_t     blk,
    output core_stat_t stat,
    output chain_t     chain
);

    typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FOLD} core_state_t;

    core_state_t         state_reg, state_next;
    logic [ROUND_W-1:0]  round_reg, round_next;
    logic                done_reg, done_next;
    chain_t              v_reg, v_next;
    chain_t              abc_reg, abc_next;
    block_t              w_reg, w_next;
    logic [WORD_W-1:0]   t_reg, t_next;

    logic [WORD_W-1:0] a, b, c, d, e, f, g, h;
    logic [WORD_W-1:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
    logic              high_round;

    assign a = abc_reg[0];
    assign b = abc_reg[1];
    assign c = abc_reg[2];
    assign d = abc_reg[3];
    assign e = abc_reg[4];
    assign f = abc_reg[5];
    assign g = abc_reg[6];
    assign h = abc_reg[7];

    assign high_round = round_reg >= ROUND_W'(LOW_ROUNDS);

    always_comb begin
        a12 = rotl32(a, 12);
        ss1 = rotl32(a12 + e + t_reg, 7);
        ss2 = ss1 ^ a12;
        if (high_round) begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
        end else begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
        end
        tt1 = ff + d + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + h + ss1 + w_reg[0];
        w_new = perm1(w_reg[0] ^ w_reg[7] ^ rotl32(w_reg[13], 15))
              ^ rotl32(w_reg[3], 7) ^ w_reg[10];
    end

    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        done_next  = 1'b0;
        v_next     = v_reg;
        abc_next   = abc_reg;
        w_next     = w_reg;
        t_next     = t_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (ctrl.clear) begin
                    v_next = SM3_IV;
                end
                if (ctrl.start) begin
                    w_next     = blk;
                    abc_next   = v_reg;
                    t_next     = T_LOW;
                    round_next = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND: begin
                abc_next[7] = g;
                abc_next[6] = rotl32(f, 19);
                abc_next[5] = e;
                abc_next[4] = perm0(tt2);
                abc_next[3] = c;
                abc_next[2] = rotl32(b, 9);
                abc_next[1] = a;
                abc_next[0] = tt1;
                w_next = {w_new, w_reg[BLOCK_WORDS-1:1]};
                if (round_reg == ROUND_W'(LOW_ROUNDS - 1)) begin
                    t_next = rotl32(T_HIGH, LOW_ROUNDS);
                end else begin
                    t_next = rotl32(t_reg, 1);
                end
                round_next = round_reg + 1'b1;
                if (round_reg == ROUND_W'(ROUNDS - 1)) begin
                    state_next = C_FOLD;
                end
            end
            C_FOLD: begin
                v_next     = v_reg ^ abc_reg;
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            done_reg  <= 1'b0;
            v_reg     <= SM3_IV;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            done_reg  <= done_next;
            v_reg     <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        abc_reg <= abc_next;
        w_reg   <= w_next;
        t_reg   <= t_next;
    end

    assign stat.done = done_reg;
    assign chain     = v_reg;

endmodule

// File: hw/rtl/sm3_message_hash.sv
// sm3 message hash top level: word buffering, padding and digest output
// usage:
//   s_ channel takes message words, first byte in bits 31..24. every word that
//   is not marked end_of_message counts as four bytes; the end word carries
//   0 to 4 leading valid bytes (codes above 4 count as 4).
//   m_ channel returns the eight digest words A..H, the eighth with
//   digest_last set.
// timing:
//   a plain word is taken while s_ready is high. the sixteenth word of a block
//   starts the shared round unit, one round per cycle, and s_ready stays low
//   until the unit finishes its 64 rounds plus load, fold and handoff, so no
//   new word is taken while a block runs. the end word runs one block, or two
//   blocks when the padded tail reaches byte 56; then the digest words follow,
//   one per cycle while m_ready is high.
// reset and stalls:
//   reset loads the initial vector and clears the fill count and bit length.
//   a stalled receiver holds the current digest word; no new word is taken
//   until the last digest word is taken, after which the block restarts from
//   the initial vector.
module sm3_message_hash
    import sm3_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sm3_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output sm3_out_t m_payload
);

    typedef enum logic [2:0] {S_IDLE, S_BLOCK, S_FINAL, S_EXTRA, S_OUT} top_state_t;

    top_state_t             state_reg, state_next;
    block_t                 buf_reg, buf_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [63:0]            len_reg, len_next;
    logic                   start_reg, start_next;
    logic                   clear_reg, clear_next;
    logic                   two_reg, two_next;
    logic                   mark_reg, mark_next;
    logic [OUT_IDX_W-1:0]   out_idx_reg, out_idx_next;

    core_ctrl_t core_ctrl;
    core_stat_t core_stat;
    chain_t     chain;

    logic        in_fire;
    logic [2:0]  nv;
    logic [63:0] len_sum;
    logic        two_blocks;
    block_t      blk_first, blk_second;

    assign in_fire = s_valid && s_ready;
    assign nv = (s_payload.valid_bytes > FULL_BYTES) ? FULL_BYTES : s_payload.valid_bytes;
    assign len_sum = len_reg + {58'd0, nv, 3'd0};
    assign two_blocks = (fill_reg >= FILL_W'(LEN_WORD))
                     || ((fill_reg == FILL_W'(LEN_WORD - 1)) && (nv == FULL_BYTES));

    always_comb begin
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            if (i < int'(fill_reg)) begin
                blk_first[i] = buf_reg[i];
            end else if (i == int'(fill_reg)) begin
                blk_first[i] = pad_tail(s_payload.message_word, nv);
            end else if ((i == int'(fill_reg) + 1) && (nv == FULL_BYTES)) begin
                blk_first[i] = MARKER_WORD;
            end else begin
                blk_first[i] = '0;
            end
        end
        if (!two_blocks) begin
            blk_first[LEN_WORD]     = len_sum[63:32];
            blk_first[LEN_WORD + 1] = len_sum[31:0];
        end
        blk_second               = '0;
        blk_second[0]            = mark_reg ? MARKER_WORD : '0;
        blk_second[LEN_WORD]     = len_reg[63:32];
        blk_second[LEN_WORD + 1] = len_reg[31:0];
    end

    always_comb begin
        state_next   = state_reg;
        buf_next     = buf_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        start_next   = 1'b0;
        clear_next   = 1'b0;
        two_next     = two_reg;
        mark_next    = mark_reg;
        out_idx_next = out_idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (!s_payload.end_of_message) begin
                        buf_next[fill_reg] = s_payload.message_word;
                        len_next = len_reg + 64'd32;
                        if (&fill_reg) begin
                            fill_next  = '0;
                            start_next = 1'b1;
                            state_next = S_BLOCK;
                        end else begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end else begin
                        buf_next   = blk_first;
                        len_next   = len_sum;
                        two_next   = two_blocks;
                        mark_next  = (&fill_reg) && (nv == FULL_BYTES);
                        start_next = 1'b1;
                        state_next = S_FINAL;
                    end
                end
            end
            S_BLOCK: begin
                if (core_stat.done) begin
                    state_next = S_IDLE;
                end
            end
            S_FINAL: begin
                if (core_stat.done) begin
                    if (two_reg) begin
                        buf_next   = blk_second;
                        start_next = 1'b1;
                        state_next = S_EXTRA;
                    end else begin
                        out_idx_next = '0;
                        state_next   = S_OUT;
                    end
                end
            end
            S_EXTRA: begin
                if (core_stat.done) begin
                    out_idx_next = '0;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    if (&out_idx_reg) begin
                        clear_next = 1'b1;
                        fill_next  = '0;
                        len_next   = '0;
                        state_next = S_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            len_reg     <= '0;
            start_reg   <= 1'b0;
            clear_reg   <= 1'b0;
            two_reg     <= 1'b0;
            mark_reg    <= 1'b0;
            out_idx_reg <= '0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            len_reg     <= len_next;
            start_reg   <= start_next;
            clear_reg   <= clear_next;
            two_reg     <= two_next;
            mark_reg    <= mark_next;
            out_idx_reg <= out_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign core_ctrl.start = start_reg;
    assign core_ctrl.clear = clear_reg;

    sm3_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (core_ctrl),
        .blk     (buf_reg),
        .stat    (core_stat),
        .chain   (chain)
    );

    assign s_ready               = (state_reg == S_IDLE);
    assign m_valid               = (state_reg == S_OUT);
    assign m_payload.digest_word = chain[out_idx_reg];
    assign m_payload.digest_last = &out_idx_reg;

    // never take a word while a digest word is offered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted during digest output");

    // the round unit starts only after an accepted word or a finished block
    a_start_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> ($past(in_fire) || $past(core_stat.done)))
        else $error("round unit started without cause");

    // after the last digest word the message state is back to empty
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_payload.digest_last)
        |=> (fill_reg == '0) && (len_reg == '0) && clear_reg && s_ready)
        else $error("state not cleared after digest");

    // a block completes only while the top is waiting on it
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        core_stat.done |-> ((state_reg == S_BLOCK) || (state_reg == S_FINAL)
                            || (state_reg == S_EXTRA)))
        else $error("round unit finished while not awaited");

endmodule
